FILE: design/igc_pkg.sv
package igc_pkg;

    // Table depths
    localparam int EXACT_DEPTH  = 256;
    localparam int SUBNET_DEPTH = 64;
    localparam int RANGE_DEPTH  = 64;

    // Address widths of the tables (at least one bit)
    localparam int EXACT_AW  = (EXACT_DEPTH  > 1) ? $clog2(EXACT_DEPTH)  : 1;
    localparam int SUBNET_AW = (SUBNET_DEPTH > 1) ? $clog2(SUBNET_DEPTH) : 1;
    localparam int RANGE_AW  = (RANGE_DEPTH  > 1) ? $clog2(RANGE_DEPTH)  : 1;

    // Widths able to hold a clamped entry count (0 up to depth)
    localparam int EXACT_CW  = $clog2(EXACT_DEPTH + 1);
    localparam int SUBNET_CW = $clog2(SUBNET_DEPTH + 1);
    localparam int RANGE_CW  = $clog2(RANGE_DEPTH + 1);
    localparam int SCAN_CW   = (SUBNET_CW > RANGE_CW) ? SUBNET_CW : RANGE_CW;

    // Register widths
    localparam int EXACT_COUNT_W  = 9;
    localparam int SUBNET_COUNT_W = 7;
    localparam int RANGE_COUNT_W  = 7;
    localparam int CFG_DATA_W     = 9;
    localparam int CFG_INDEX_W    = 2;

    // Register indexes
    localparam logic [CFG_INDEX_W-1:0] CFG_EXACT_COUNT  = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_SUBNET_COUNT = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_RANGE_COUNT  = 2'd2;

    // Field widths
    localparam int ADDR_W  = 32;
    localparam int GROUP_W = 8;
    localparam int SLOT_W  = 8;
    localparam int MODE_W  = 2;
    localparam int KIND_W  = 2;

    // Stream payload widths
    localparam int IN_DATA_W  = 80;
    localparam int OUT_DATA_W = 16;

    // RAM word widths
    localparam int EXACT_WORD_W = ADDR_W + GROUP_W;
    localparam int PAIR_WORD_W  = 2 * ADDR_W + GROUP_W;

    // Item modes
    localparam logic [MODE_W-1:0] MODE_LOOKUP = 2'd0;
    localparam logic [MODE_W-1:0] MODE_EXACT  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_SUBNET = 2'd2;
    localparam logic [MODE_W-1:0] MODE_RANGE  = 2'd3;

    // Match kinds
    localparam logic [KIND_W-1:0] KIND_EXACT  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_SUBNET = 2'd1;
    localparam logic [KIND_W-1:0] KIND_RANGE  = 2'd2;
    localparam logic [KIND_W-1:0] KIND_NONE   = 2'd3;

    // Compare unit operations
    typedef enum logic [1:0] {
        OP_EXACT,
        OP_SUBNET,
        OP_RANGE
    } t_cmp_op;

    typedef struct packed {
        logic eq;
        logic lt;
        logic hit;
    } t_cmp_res;

endpackage

FILE: design/igc_ram.sv
module igc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                                          i_clk,
    input  logic                                          i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                              i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                              o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // One write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: design/igc_cmp.sv
module igc_cmp (
    input  logic [igc_pkg::ADDR_W-1:0] i_addr,
    input  logic [igc_pkg::ADDR_W-1:0] i_a,
    input  logic [igc_pkg::ADDR_W-1:0] i_b,
    input  igc_pkg::t_cmp_op           i_op,
    output igc_pkg::t_cmp_res          o_res
);
    import igc_pkg::*;

    logic [ADDR_W-1:0] key;
    logic              eq;
    logic              lt;

    // Subnet compares against the masked address, the others the plain one
    assign key = (i_op == OP_SUBNET) ? (i_addr & i_b) : i_addr;
    assign eq  = (i_a == key);
    assign lt  = (i_a < key);

    always_comb begin
        o_res.eq = eq;
        o_res.lt = lt;
        unique case (i_op)
            OP_EXACT:  o_res.hit = eq;
            OP_SUBNET: o_res.hit = eq;
            OP_RANGE:  o_res.hit = (lt | eq) & (i_addr <= i_b);
            default:   o_res.hit = 1'b0;
        endcase
    end

endmodule

FILE: design/ipv4_group_classifier.sv
// Channel   Dir  Handshake                       Payload
// s_axis    in   s_axis_tvalid / s_axis_tready   tuser: mode; tdata: slot, address, word, group
// m_axis    out  m_axis_tvalid / m_axis_tready   tuser: match_kind; tdata: matched, group
// cfg       in   i_cfg_we (no wait)              i_cfg_index, i_cfg_data
//
// Write items go from accept through the hold state back to idle. A lookup runs a
// binary search over the exact RAM, each step a read state and a compare state, then a
// closing read state; then a pipelined scan of the subnet and then the range table, up
// to the first hit, one RAM read and one compare-unit pass per cycle; then the hold state
// hands the result off and the sequencer returns to idle to accept the next item.
// Reset clears counts and control; table RAMs keep no reset. A result waits in the
// output register while the next item is accepted; the sequencer holds a finished
// result only while the output register is still occupied.
module ipv4_group_classifier (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // input stream
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [igc_pkg::IN_DATA_W-1:0]     s_axis_tdata,  // entry_index[7:0],
                                                             // address[39:8],
                                                             // second_word[71:40],
                                                             // filter_group[79:72]
    input  logic [igc_pkg::MODE_W-1:0]        s_axis_tuser,  // mode[1:0]
    // result stream
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    output logic [igc_pkg::OUT_DATA_W-1:0]    m_axis_tdata,  // matched[0],
                                                             // result_group[8:1], zero fill
    output logic [igc_pkg::KIND_W-1:0]        m_axis_tuser,  // match_kind[1:0]
    // configuration
    input  logic                              i_cfg_we,
    input  logic [igc_pkg::CFG_INDEX_W-1:0]   i_cfg_index,
    input  logic [igc_pkg::CFG_DATA_W-1:0]    i_cfg_data
);
    import igc_pkg::*;

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_EX_RD  = 3'd1;
    localparam logic [2:0] S_EX_CMP = 3'd2;
    localparam logic [2:0] S_SN     = 3'd3;
    localparam logic [2:0] S_RG     = 3'd4;
    localparam logic [2:0] S_HOLD   = 3'd5;

    // Unpacked input fields
    logic [MODE_W-1:0]  in_mode;
    logic [SLOT_W-1:0]  in_slot;
    logic [ADDR_W-1:0]  in_addr;
    logic [ADDR_W-1:0]  in_word;
    logic [GROUP_W-1:0] in_group;
    logic               in_accept;
    logic               out_accept;

    assign in_mode    = s_axis_tuser;
    assign in_slot    = s_axis_tdata[7:0];
    assign in_addr    = s_axis_tdata[39:8];
    assign in_word    = s_axis_tdata[71:40];
    assign in_group   = s_axis_tdata[79:72];
    assign in_accept  = s_axis_tvalid & s_axis_tready;
    assign out_accept = m_axis_tvalid & m_axis_tready;

    // Configuration registers
    logic [EXACT_COUNT_W-1:0]  r_exact_count;
    logic [SUBNET_COUNT_W-1:0] r_subnet_count;
    logic [RANGE_COUNT_W-1:0]  r_range_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_exact_count  <= '0;
            r_subnet_count <= '0;
            r_range_count  <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_EXACT_COUNT:  r_exact_count  <= i_cfg_data[EXACT_COUNT_W-1:0];
                CFG_SUBNET_COUNT: r_subnet_count <= i_cfg_data[SUBNET_COUNT_W-1:0];
                CFG_RANGE_COUNT:  r_range_count  <= i_cfg_data[RANGE_COUNT_W-1:0];
                default: ;
            endcase
        end
    end

    // Counts saturated to the table depths
    logic [31:0]          exact_n32;
    logic [31:0]          subnet_n32;
    logic [31:0]          range_n32;
    logic [EXACT_CW-1:0]  exact_n;
    logic [SCAN_CW-1:0]   subnet_n;
    logic [SCAN_CW-1:0]   range_n;

    assign exact_n32  = (32'(r_exact_count) > 32'(EXACT_DEPTH)) ?
                        32'(EXACT_DEPTH) : 32'(r_exact_count);
    assign subnet_n32 = (32'(r_subnet_count) > 32'(SUBNET_DEPTH)) ?
                        32'(SUBNET_DEPTH) : 32'(r_subnet_count);
    assign range_n32  = (32'(r_range_count) > 32'(RANGE_DEPTH)) ?
                        32'(RANGE_DEPTH) : 32'(r_range_count);
    assign exact_n    = exact_n32[EXACT_CW-1:0];
    assign subnet_n   = subnet_n32[SCAN_CW-1:0];
    assign range_n    = range_n32[SCAN_CW-1:0];

    // Table writes, done at the accept edge of a write item
    logic [31:0]          slot32;
    logic                 ex_we;
    logic                 sn_we;
    logic                 rg_we;

    assign slot32 = 32'(in_slot);
    assign ex_we  = in_accept & (in_mode == MODE_EXACT)  & (slot32 < 32'(EXACT_DEPTH));
    assign sn_we  = in_accept & (in_mode == MODE_SUBNET) & (slot32 < 32'(SUBNET_DEPTH));
    assign rg_we  = in_accept & (in_mode == MODE_RANGE)  & (slot32 < 32'(RANGE_DEPTH));

    // Sequencer registers
    logic [2:0]          r_state, n_state;
    logic [ADDR_W-1:0]   r_addr, n_addr;
    logic [EXACT_CW-1:0] r_lo, n_lo;
    logic [EXACT_CW-1:0] r_hi1, n_hi1;      // search bound, exclusive
    logic [EXACT_CW-1:0] r_mid, n_mid;
    logic [SCAN_CW-1:0]  r_idx, n_idx;
    logic                r_pend, n_pend;    // RAM data of r_idx-1 is valid
    logic [GROUP_W-1:0]  r_res_group, n_res_group;
    logic [KIND_W-1:0]   r_res_kind, n_res_kind;

    // Output register
    logic                r_out_valid, n_out_valid;
    logic [GROUP_W-1:0]  r_out_group, n_out_group;
    logic [KIND_W-1:0]   r_out_kind, n_out_kind;

    // Binary-search midpoint: (lo + hi) / 2 with hi = hi1 - 1
    logic [EXACT_CW:0]   mid_sum;
    logic [EXACT_CW-1:0] mid;

    assign mid_sum = {1'b0, r_lo} + {1'b0, r_hi1} - {{EXACT_CW{1'b0}}, 1'b1};
    assign mid     = mid_sum[EXACT_CW:1];

    // Table RAMs
    logic [EXACT_WORD_W-1:0] ex_rdata;
    logic [PAIR_WORD_W-1:0]  sn_rdata;
    logic [PAIR_WORD_W-1:0]  rg_rdata;
    logic [EXACT_AW-1:0]     ex_waddr;
    logic [SUBNET_AW-1:0]    sn_waddr;
    logic [RANGE_AW-1:0]     rg_waddr;

    assign ex_waddr = slot32[EXACT_AW-1:0];
    assign sn_waddr = slot32[SUBNET_AW-1:0];
    assign rg_waddr = slot32[RANGE_AW-1:0];

    igc_ram #(.WIDTH(EXACT_WORD_W), .DEPTH(EXACT_DEPTH)) u_exact_ram (
        .i_clk   (i_clk),
        .i_we    (ex_we),
        .i_waddr (ex_waddr),
        .i_wdata ({in_group, in_addr}),
        .i_raddr (mid[EXACT_AW-1:0]),
        .o_rdata (ex_rdata)
    );

    igc_ram #(.WIDTH(PAIR_WORD_W), .DEPTH(SUBNET_DEPTH)) u_subnet_ram (
        .i_clk   (i_clk),
        .i_we    (sn_we),
        .i_waddr (sn_waddr),
        .i_wdata ({in_group, in_word, in_addr & in_word}),
        .i_raddr (r_idx[SUBNET_AW-1:0]),
        .o_rdata (sn_rdata)
    );

    igc_ram #(.WIDTH(PAIR_WORD_W), .DEPTH(RANGE_DEPTH)) u_range_ram (
        .i_clk   (i_clk),
        .i_we    (rg_we),
        .i_waddr (rg_waddr),
        .i_wdata ({in_group, in_word, in_addr}),
        .i_raddr (r_idx[RANGE_AW-1:0]),
        .o_rdata (rg_rdata)
    );

    // Shared compare unit, operands chosen by the sequencer state
    t_cmp_op            cmp_op;
    logic [ADDR_W-1:0]  cmp_a;
    logic [ADDR_W-1:0]  cmp_b;
    logic [GROUP_W-1:0] cmp_group;
    t_cmp_res           cmp_res;

    always_comb begin
        priority if (r_state == S_SN) begin
            cmp_op    = OP_SUBNET;
            cmp_a     = sn_rdata[ADDR_W-1:0];
            cmp_b     = sn_rdata[2*ADDR_W-1:ADDR_W];
            cmp_group = sn_rdata[PAIR_WORD_W-1:2*ADDR_W];
        end else if (r_state == S_RG) begin
            cmp_op    = OP_RANGE;
            cmp_a     = rg_rdata[ADDR_W-1:0];
            cmp_b     = rg_rdata[2*ADDR_W-1:ADDR_W];
            cmp_group = rg_rdata[PAIR_WORD_W-1:2*ADDR_W];
        end else begin
            cmp_op    = OP_EXACT;
            cmp_a     = ex_rdata[ADDR_W-1:0];
            cmp_b     = '0;
            cmp_group = ex_rdata[EXACT_WORD_W-1:ADDR_W];
        end
    end

    igc_cmp u_cmp (
        .i_addr (r_addr),
        .i_a    (cmp_a),
        .i_b    (cmp_b),
        .i_op   (cmp_op),
        .o_res  (cmp_res)
    );

    assign s_axis_tready = (r_state == S_IDLE);

    // Sequencer
    always_comb begin
        n_state     = r_state;
        n_addr      = r_addr;
        n_lo        = r_lo;
        n_hi1       = r_hi1;
        n_mid       = r_mid;
        n_idx       = r_idx;
        n_pend      = r_pend;
        n_res_group = r_res_group;
        n_res_kind  = r_res_kind;
        n_out_valid = r_out_valid & ~out_accept;
        n_out_group = r_out_group;
        n_out_kind  = r_out_kind;

        unique case (r_state)
            S_IDLE: begin
                if (in_accept) begin
                    n_addr      = in_addr;
                    n_lo        = '0;
                    n_hi1       = exact_n;
                    n_res_group = '0;
                    n_res_kind  = KIND_NONE;
                    n_state     = (in_mode == MODE_LOOKUP) ? S_EX_RD : S_HOLD;
                end
            end
            S_EX_RD: begin
                // read issued at mid while the search window is not empty
                n_mid  = mid;
                n_idx  = '0;
                n_pend = 1'b0;
                n_state = (r_lo < r_hi1) ? S_EX_CMP : S_SN;
            end
            S_EX_CMP: begin
                priority if (cmp_res.eq) begin
                    n_res_group = cmp_group;
                    n_res_kind  = KIND_EXACT;
                    n_state     = S_HOLD;
                end else if (cmp_res.lt) begin
                    n_lo    = r_mid + 1'b1;
                    n_state = S_EX_RD;
                end else begin
                    n_hi1   = r_mid;
                    n_state = S_EX_RD;
                end
            end
            S_SN, S_RG: begin
                // compare data of r_idx-1 while the read of r_idx is issued
                priority if (r_pend && cmp_res.hit) begin
                    n_res_group = cmp_group;
                    n_res_kind  = (r_state == S_SN) ? KIND_SUBNET : KIND_RANGE;
                    n_state     = S_HOLD;
                end else if (r_idx < ((r_state == S_SN) ? subnet_n : range_n)) begin
                    n_idx  = r_idx + 1'b1;
                    n_pend = 1'b1;
                end else begin
                    n_idx   = '0;
                    n_pend  = 1'b0;
                    n_state = (r_state == S_SN) ? S_RG : S_HOLD;
                end
            end
            S_HOLD: begin
                if (!r_out_valid || out_accept) begin
                    n_out_valid = 1'b1;
                    n_out_group = r_res_group;
                    n_out_kind  = r_res_kind;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_pend      <= n_pend;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_addr      <= n_addr;
        r_lo        <= n_lo;
        r_hi1       <= n_hi1;
        r_mid       <= n_mid;
        r_idx       <= n_idx;
        r_res_group <= n_res_group;
        r_res_kind  <= n_res_kind;
        r_out_group <= n_out_group;
        r_out_kind  <= n_out_kind;
    end

    // Result stream
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {7'b0, r_out_group, (r_out_kind != KIND_NONE)};
    assign m_axis_tuser  = r_out_kind;

endmodule
